// File: sv/cvps_pkg.sv
// Package for the closest value pair search block.
// Holds data widths and the command/status structs between controller and datapath.
// No dependencies.
package cvps_pkg;

    localparam int DATA_W = 32;
    localparam int DIFF_W = DATA_W + 1;

    typedef struct packed {
        logic load;
        logic clear_i;
        logic set_j;
        logic latch_a;
        logic rd_j;
        logic next_i;
        logic out_load;
    } cvps_cmd_t;

    typedef struct packed {
        logic count_ge2;
        logic j_last;
        logic i_last;
        logic out_free;
    } cvps_sts_t;

endpackage

// File: sv/cvps_ctrl.sv
// Controller state machine for the closest value pair search.
// Sequences loading, the pairwise scan and the result hand-off.
// Depends on cvps_pkg.
module cvps_ctrl
    import cvps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_is_last,
    input  cvps_sts_t sts,
    output cvps_cmd_t cmd
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_RDA   = 3'd2;
    localparam logic [2:0] S_ROWF  = 3'd3;
    localparam logic [2:0] S_ROW   = 3'd4;
    localparam logic [2:0] S_W1    = 3'd5;
    localparam logic [2:0] S_W2    = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && s_is_last) begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                cmd.clear_i = 1'b1;
                state_next  = sts.count_ge2 ? S_RDA : S_OUT;
            end
            S_RDA: begin
                cmd.set_j  = 1'b1;
                state_next = S_ROWF;
            end
            S_ROWF, S_ROW: begin
                cmd.latch_a = (state_reg == S_ROWF);
                cmd.rd_j    = 1'b1;
                if (sts.j_last) begin
                    if (sts.i_last) begin
                        state_next = S_W1;
                    end else begin
                        cmd.next_i = 1'b1;
                        state_next = S_RDA;
                    end
                end else begin
                    state_next = S_ROW;
                end
            end
            S_W1: begin
                state_next = S_W2;
            end
            S_W2: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while output slot busy");

    a_row_needs_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROWF) |-> sts.count_ge2)
        else $error("scan entered with fewer than two values");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> s_ready)
        else $error("not ready for a new set after result");

endmodule

// File: sv/cvps_dp.sv
// Datapath for the closest value pair search: value store, scan counters,
// difference and compare pipeline, best-pair and output registers.
// Depends on cvps_pkg.
module cvps_dp
    import cvps_pkg::*;
#(
    parameter int MAX_VALUES = 256
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cvps_cmd_t                cmd,
    output cvps_sts_t                sts,
    input  logic signed [DATA_W-1:0] s_sample_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_larger_value,
    output logic signed [DATA_W-1:0] m_smaller_value,
    output logic                     m_pair_found,
    output logic                     m_overflowed
);

    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CW = $clog2(MAX_VALUES + 1);

    logic [DATA_W-1:0] value_mem [MAX_VALUES];
    logic [DATA_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;

    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic [AW-1:0] i_reg;
    logic [AW-1:0] j_reg;
    logic          has_room;

    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] b_val;
    logic                     bv_reg;

    logic signed [DIFF_W-1:0] d_ab;
    logic signed [DIFF_W-1:0] d_ba;
    logic                     a_gt;

    logic                     dv_reg;
    logic [DIFF_W-1:0]        diff_reg;
    logic signed [DATA_W-1:0] lg_reg;
    logic signed [DATA_W-1:0] sm_reg;

    logic [DIFF_W-1:0]        best_diff_reg;
    logic signed [DATA_W-1:0] best_lg_reg;
    logic signed [DATA_W-1:0] best_sm_reg;

    logic m_valid_reg;

    assign has_room = (count_reg < CW'(MAX_VALUES));
    assign rd_addr  = cmd.rd_j ? j_reg : i_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load && has_room) begin
            value_mem[count_reg[AW-1:0]] <= s_sample_value;
        end
        rd_data_reg <= value_mem[rd_addr];
    end

    assign sts.count_ge2 = (count_reg >= CW'(2));
    assign sts.j_last    = (CW'(j_reg) == count_reg - CW'(1));
    assign sts.i_last    = (CW'(i_reg) == count_reg - CW'(2));
    assign sts.out_free  = !m_valid_reg || m_ready;

    // set bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.out_load) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.load) begin
            if (has_room) begin
                count_reg <= count_reg + CW'(1);
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_i) begin
            i_reg <= '0;
        end else if (cmd.next_i) begin
            i_reg <= i_reg + AW'(1);
        end
        if (cmd.set_j) begin
            j_reg <= i_reg + AW'(1);
        end else if (cmd.rd_j) begin
            j_reg <= j_reg + AW'(1);
        end
        if (cmd.latch_a) begin
            a_reg <= rd_data_reg;
        end
    end

    // stage 1: exact 33-bit difference
    assign b_val = rd_data_reg;
    assign d_ab  = {a_reg[DATA_W-1], a_reg} - {b_val[DATA_W-1], b_val};
    assign d_ba  = {b_val[DATA_W-1], b_val} - {a_reg[DATA_W-1], a_reg};
    assign a_gt  = !d_ab[DIFF_W-1] && (d_ab != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= 1'b0;
            dv_reg <= 1'b0;
        end else begin
            bv_reg <= cmd.rd_j;
            dv_reg <= bv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg <= a_gt ? d_ab : d_ba;
        lg_reg   <= a_gt ? a_reg : b_val;
        sm_reg   <= a_gt ? b_val : a_reg;
    end

    // stage 2: keep the first strictly smaller difference
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.out_load) begin
            best_diff_reg <= '1;
            best_lg_reg   <= '0;
            best_sm_reg   <= '0;
        end else if (dv_reg && (diff_reg < best_diff_reg)) begin
            best_diff_reg <= diff_reg;
            best_lg_reg   <= lg_reg;
            best_sm_reg   <= sm_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_larger_value  <= best_lg_reg;
            m_smaller_value <= best_sm_reg;
            m_pair_found    <= sts.count_ge2;
            m_overflowed    <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: sv/closest_value_pair_search.sv
// Closest value pair search, top level. Loaded values are taken one per cycle while the
// block is loading; after the beat marked last, two or more stored values are scanned
// pairwise, one compare per cycle within a row (single store read port).
// Input is not taken during the scan; a finished result waits in an output register.
// Reset: aresetn synchronous active low; clears count, overflow flag and best pair.
// Depends on cvps_pkg, cvps_ctrl, cvps_dp.
module closest_value_pair_search
    import cvps_pkg::*;
#(
    parameter int MAX_VALUES = 256
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_sample_value,
    input  logic                     s_is_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_larger_value,
    output logic signed [DATA_W-1:0] m_smaller_value,
    output logic                     m_pair_found,
    output logic                     m_overflowed
);

    cvps_cmd_t cmd;
    cvps_sts_t sts;

    cvps_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_is_last (s_is_last),
        .sts       (sts),
        .cmd       (cmd)
    );

    cvps_dp #(
        .MAX_VALUES (MAX_VALUES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_sample_value  (s_sample_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_larger_value  (m_larger_value),
        .m_smaller_value (m_smaller_value),
        .m_pair_found    (m_pair_found),
        .m_overflowed    (m_overflowed)
    );

endmodule

// File: test/tb_closest_value_pair_search.sv
// Testbench for closest_value_pair_search: streams value sets, predicts the closest pair of each
// set and checks every result beat. Uses cvps_pkg for data widths; needs only the RTL.
// Covers degenerate sets, extremes, tie order, full and overflowing store, output backpressure.
module tb_closest_value_pair_search
    import cvps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 4;
    localparam int STORE_DEPTH = 256;
    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_PCT    = 31;

    typedef logic signed [DATA_W-1:0] sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] larger;
        logic signed [DATA_W-1:0] smaller;
        logic                     found;
        logic                     ovf;
    } pair_result_t;

    localparam sample_t VAL_MAX = 32'sh7FFF_FFFF;
    localparam sample_t VAL_MIN = 32'sh8000_0000;

    logic    aclk = 1'b0;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    sample_t s_sample_value;
    logic    s_is_last;
    logic    m_valid;
    logic    m_ready;
    sample_t m_larger_value;
    sample_t m_smaller_value;
    logic    m_pair_found;
    logic    m_overflowed;

    sample_t      set_vals[STORE_DEPTH];
    int           set_count;
    bit           set_overflow;
    pair_result_t expected_pairs[$];

    int mismatches;
    int items_sent;
    int cycles;
    bit tx_steady;
    bit rx_steady;
    int rx_hold;

    closest_value_pair_search #(
        .MAX_VALUES(STORE_DEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_is_last      (s_is_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_larger_value (m_larger_value),
        .m_smaller_value(m_smaller_value),
        .m_pair_found   (m_pair_found),
        .m_overflowed   (m_overflowed)
    );

    always #(CLK_PERIOD/2) aclk = ~aclk;

    function automatic pair_result_t find_closest_pair();
        pair_result_t     r;
        logic [DIFF_W-1:0] best;
        logic [DIFF_W-1:0] d;
        longint           a;
        longint           b;
        r    = '0;
        best = '1;
        for (int i = 0; i + 1 < set_count; i++) begin
            a = set_vals[i];
            for (int j = i + 1; j < set_count; j++) begin
                b = set_vals[j];
                d = (a > b) ? DIFF_W'(a - b) : DIFF_W'(b - a);
                if (d < best) begin
                    best     = d;
                    r.larger  = (a > b) ? set_vals[i] : set_vals[j];
                    r.smaller = (a > b) ? set_vals[j] : set_vals[i];
                end
            end
        end
        r.found = (set_count >= 2);
        r.ovf   = set_overflow;
        return r;
    endfunction

    task automatic absorb_sample(input sample_t value, input logic last);
        if (set_count < STORE_DEPTH) begin
            set_vals[set_count] = value;
            set_count++;
        end else begin
            set_overflow = 1'b1;
        end
        if (last) begin
            expected_pairs.push_back(find_closest_pair());
            set_count    = 0;
            set_overflow = 1'b0;
        end
    endtask

    task automatic send_sample(input sample_t value, input logic last);
        while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_value <= value;
        s_is_last      <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        absorb_sample(value, last);
    endtask

    function automatic sample_t pick_sample(input sample_t base);
        case ($urandom_range(9))
            0, 1, 2, 3: return sample_t'($urandom);
            4, 5, 6:    return base + sample_t'($urandom_range(16)) - 8;
            7:          return VAL_MAX - sample_t'($urandom_range(3));
            8:          return VAL_MIN + sample_t'($urandom_range(3));
            default:    return sample_t'($urandom_range(6)) - 3;
        endcase
    endfunction

    task automatic send_random_set(input int size);
        sample_t base;
        base = sample_t'($urandom);
        for (int k = 0; k < size; k++)
            send_sample(pick_sample(base), k == size - 1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_pairs.size() > 0)
            @(posedge aclk);
    endtask

    task automatic test_degenerate_sets();
        send_sample(VAL_MIN, 1'b1);
        send_sample(VAL_MAX, 1'b1);
        send_sample(32'sd0, 1'b1);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd0, 1'b1);
    endtask

    task automatic test_extreme_values();
        send_sample(VAL_MIN, 1'b0);
        send_sample(VAL_MAX, 1'b1);
        send_sample(VAL_MAX, 1'b0);
        send_sample(VAL_MIN, 1'b0);
        send_sample(32'sd0, 1'b1);
        send_sample(VAL_MAX, 1'b0);
        send_sample(VAL_MAX - 1, 1'b1);
    endtask

    task automatic test_equal_values();
        send_sample(-32'sd7, 1'b0);
        send_sample(32'sd42, 1'b0);
        send_sample(-32'sd7, 1'b1);
    endtask

    task automatic test_tie_order();
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd5, 1'b1);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd1, 1'b1);
        send_sample(32'sd10, 1'b0);
        send_sample(-32'sd10, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(32'sd20, 1'b1);
    endtask

    // exactly full store, then a set whose tail (including the last beat) is dropped
    task automatic test_store_full();
        sample_t base;
        base = sample_t'($urandom);
        for (int k = 0; k < STORE_DEPTH; k++)
            send_sample(pick_sample(base), k == STORE_DEPTH - 1);
        for (int k = 0; k < STORE_DEPTH + 4; k++)
            send_sample(pick_sample(base), k == STORE_DEPTH + 3);
    endtask

    task automatic test_output_stall();
        rx_hold = 1500;
        for (int k = 0; k < 6; k++)
            send_random_set(4);
    endtask

    task automatic test_back_to_back();
        int start;
        start     = items_sent;
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        while (items_sent - start < 100)
            send_random_set($urandom_range(1, 8));
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_random_sets();
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < 150) begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_random_set(1);
            else if (pick < 80)
                send_random_set($urandom_range(2, 10));
            else if (pick < 96)
                send_random_set($urandom_range(11, 32));
            else
                send_random_set($urandom_range(33, 64));
        end
    endtask

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        if (mismatches < 10)
            $display("mismatch on %s: expected %h, got %h (cycle %0d)", field, want, got, cycles);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        pair_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pairs.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result beat at cycle %0d", cycles);
                mismatches++;
            end else begin
                want = expected_pairs.pop_front();
                if (m_larger_value !== want.larger)
                    report_mismatch("larger_value", want.larger, m_larger_value);
                if (m_smaller_value !== want.smaller)
                    report_mismatch("smaller_value", want.smaller, m_smaller_value);
                if (m_pair_found !== want.found)
                    report_mismatch("pair_found", want.found, m_pair_found);
                if (m_overflowed !== want.ovf)
                    report_mismatch("overflowed", want.ovf, m_overflowed);
            end
        end
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else begin
                m_ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        mismatches     = 0;
        items_sent     = 0;
        set_count      = 0;
        set_overflow   = 1'b0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        rx_hold        = 0;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_sample_value <= '0;
        s_is_last      <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_degenerate_sets();
        test_extreme_values();
        test_equal_values();
        test_tie_order();
        test_store_full();
        test_output_stall();
        test_back_to_back();
        test_random_sets();

        drain();
        repeat (64) @(posedge aclk);
        if (mismatches == 0 && expected_pairs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: closest_value_pair_search.f
sv/cvps_pkg.sv
sv/cvps_ctrl.sv
sv/cvps_dp.sv
sv/closest_value_pair_search.sv
test/tb_closest_value_pair_search.sv
